[src/owb_pkg.sv]
// Package for the 1-Wire bus master: field widths, register and mode codes,
// bus phase encoding, timing register set and reset values.
// No dependencies; used by the interfaces and every module in src.
package owb_pkg;

  // Field widths
  localparam int unsigned MODE_WIDTH     = 2;
  localparam int unsigned BYTE_WIDTH     = 8;
  localparam int unsigned REG_WIDTH      = 10;
  localparam int unsigned REG_IDX_WIDTH  = 3;
  localparam int unsigned BIT_IDX_WIDTH  = 3;
  localparam int unsigned COUNT_WIDTH_DEF = 10;

  // Fixed phase lengths in microseconds
  localparam logic [REG_WIDTH-1:0] PRE_HIGH_TIME       = REG_WIDTH'(2);
  localparam logic [REG_WIDTH-1:0] WRITE_RECOVERY_TIME = REG_WIDTH'(1);
  localparam logic [REG_WIDTH-1:0] DEFAULT_PHASE_TIME  = REG_WIDTH'(1);

  // Last bit of a byte
  localparam logic [BIT_IDX_WIDTH-1:0] LAST_BIT = BIT_IDX_WIDTH'(7);

  // Timing register reset values
  localparam logic [REG_WIDTH-1:0] RESET_LOW_RST     = REG_WIDTH'(480);
  localparam logic [REG_WIDTH-1:0] PRESENCE_WAIT_RST = REG_WIDTH'(80);
  localparam logic [REG_WIDTH-1:0] RESET_REC_RST     = REG_WIDTH'(400);
  localparam logic [REG_WIDTH-1:0] WRITE_START_RST   = REG_WIDTH'(5);
  localparam logic [REG_WIDTH-1:0] WRITE_HOLD_RST    = REG_WIDTH'(55);
  localparam logic [REG_WIDTH-1:0] READ_START_RST    = REG_WIDTH'(2);
  localparam logic [REG_WIDTH-1:0] READ_SAMPLE_RST   = REG_WIDTH'(8);
  localparam logic [REG_WIDTH-1:0] READ_TAIL_RST     = REG_WIDTH'(51);

  // Configuration register indexes
  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_REC     = 3'd2,
    REG_WRITE_START   = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_READ_START    = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_READ_TAIL     = 3'd7
  } cfg_reg_t;

  // Item mode codes
  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // Bus phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_PRE       = 4'd1,
    PH_RST_LOW   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_RST_REC   = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_DATA   = 4'd6,
    PH_WR_REC    = 4'd7,
    PH_RD_LOW    = 4'd8,
    PH_RD_WAIT   = 4'd9,
    PH_RD_TAIL   = 4'd10
  } phase_t;

  // Timing register set
  typedef struct packed {
    logic [REG_WIDTH-1:0] reset_low_time;
    logic [REG_WIDTH-1:0] presence_wait_time;
    logic [REG_WIDTH-1:0] reset_recovery_time;
    logic [REG_WIDTH-1:0] write_start_time;
    logic [REG_WIDTH-1:0] write_hold_time;
    logic [REG_WIDTH-1:0] read_start_time;
    logic [REG_WIDTH-1:0] read_sample_time;
    logic [REG_WIDTH-1:0] read_tail_time;
  } timing_t;

  // One result item
  typedef struct packed {
    logic                  line_release;
    logic                  busy_res;
    logic                  done_res;
    logic                  presence_level;
    logic [BYTE_WIDTH-1:0] read_byte;
  } result_t;

endpackage

[src/owb_in_if.sv]
// Input item channel of the 1-Wire bus master: valid/ready plus tick fields.
// Depends on owb_pkg.
interface owb_in_if import owb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MODE_WIDTH-1:0] mode;
  logic [BYTE_WIDTH-1:0] write_byte;
  logic                  line_level;

  modport source (output valid, mode, write_byte, line_level, input ready);
  modport sink   (input valid, mode, write_byte, line_level, output ready);
endinterface

[src/owb_out_if.sv]
// Result item channel of the 1-Wire bus master: valid/ready plus result fields.
// Depends on owb_pkg.
interface owb_out_if import owb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  line_release;
  logic                  busy_res;
  logic                  done_res;
  logic                  presence_level;
  logic [BYTE_WIDTH-1:0] read_byte;

  modport source (output valid, line_release, busy_res, done_res, presence_level,
                  read_byte, input ready);
  modport sink   (input valid, line_release, busy_res, done_res, presence_level,
                  read_byte, output ready);
endinterface

[src/owb_cfg_if.sv]
// Configuration write channel of the 1-Wire bus master: valid/ready, index, data.
// Depends on owb_pkg.
interface owb_cfg_if import owb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REG_IDX_WIDTH-1:0] index;
  logic [REG_WIDTH-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/owb_regs.sv]
// Timing register file of the 1-Wire bus master, written over the config port.
// Depends on owb_pkg.
module owb_regs import owb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [REG_IDX_WIDTH-1:0] wr_index,
  input  logic [REG_WIDTH-1:0]     wr_data,
  output timing_t                  timing
);

  cfg_reg_t reg_sel;
  assign reg_sel = cfg_reg_t'(wr_index);

  // Load reset values, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.reset_low_time      <= RESET_LOW_RST;
      timing.presence_wait_time  <= PRESENCE_WAIT_RST;
      timing.reset_recovery_time <= RESET_REC_RST;
      timing.write_start_time    <= WRITE_START_RST;
      timing.write_hold_time     <= WRITE_HOLD_RST;
      timing.read_start_time     <= READ_START_RST;
      timing.read_sample_time    <= READ_SAMPLE_RST;
      timing.read_tail_time      <= READ_TAIL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RESET_LOW:     timing.reset_low_time      <= wr_data;
        REG_PRESENCE_WAIT: timing.presence_wait_time  <= wr_data;
        REG_RESET_REC:     timing.reset_recovery_time <= wr_data;
        REG_WRITE_START:   timing.write_start_time    <= wr_data;
        REG_WRITE_HOLD:    timing.write_hold_time     <= wr_data;
        REG_READ_START:    timing.read_start_time     <= wr_data;
        REG_READ_SAMPLE:   timing.read_sample_time    <= wr_data;
        REG_READ_TAIL:     timing.read_tail_time      <= wr_data;
        default:           timing.reset_low_time      <= timing.reset_low_time;
      endcase
    end
  end

endmodule

[src/owb_core.sv]
// Bus phase sequencer of the 1-Wire bus master: one microsecond tick per step,
// phase counter compare, bit shifting and presence/read capture.
// Depends on owb_pkg.
module owb_core import owb_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [MODE_WIDTH-1:0] mode,
  input  logic [BYTE_WIDTH-1:0] write_byte,
  input  logic                  line_level,
  input  timing_t               timing,
  output result_t               result
);

  // Width that holds both a register value and the counter limit
  localparam int unsigned LIM_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
  localparam logic [LIM_WIDTH-1:0] COUNT_MAX = LIM_WIDTH'({COUNT_WIDTH{1'b1}});

  phase_t                   phase, phase_next;
  logic [COUNT_WIDTH-1:0]   tick_count, tick_count_next;
  logic [BIT_IDX_WIDTH-1:0] bit_index, bit_index_next;
  logic [BYTE_WIDTH-1:0]    shift_byte, shift_byte_next;
  logic                     presence_flag, presence_flag_next;
  logic [BYTE_WIDTH-1:0]    held_read, held_read_next;

  phase_t                   cur_phase;
  logic [COUNT_WIDTH-1:0]   cur_tick;
  logic [BIT_IDX_WIDTH-1:0] cur_bit;
  logic [BYTE_WIDTH-1:0]    cur_shift;
  logic [REG_WIDTH-1:0]     ph_time;
  logic [REG_WIDTH-1:0]     ph_last_raw;
  logic [LIM_WIDTH-1:0]     ph_last_ext;
  logic [COUNT_WIDTH-1:0]   ph_last;
  logic                     phase_end;
  mode_t                    mode_sel;

  assign mode_sel = mode_t'(mode);

  // Start an operation from idle on the same tick
  always_comb begin
    cur_phase = phase;
    cur_tick  = tick_count;
    cur_bit   = bit_index;
    cur_shift = shift_byte;
    if (phase == PH_IDLE) begin
      cur_tick = '0;
      cur_bit  = '0;
      unique case (mode_sel)
        MODE_RESET: cur_phase = PH_PRE;
        MODE_WRITE: begin
          cur_phase = PH_WR_LOW;
          cur_shift = write_byte;
        end
        MODE_READ: begin
          cur_phase = PH_RD_LOW;
          cur_shift = '0;
        end
        default: cur_phase = PH_IDLE;
      endcase
    end
  end

  // Look up phase length, find the last count, saturate to the counter
  always_comb begin
    unique case (cur_phase)
      PH_PRE:       ph_time = PRE_HIGH_TIME;
      PH_RST_LOW:   ph_time = timing.reset_low_time;
      PH_PRES_WAIT: ph_time = timing.presence_wait_time;
      PH_RST_REC:   ph_time = timing.reset_recovery_time;
      PH_WR_LOW:    ph_time = timing.write_start_time;
      PH_WR_DATA:   ph_time = timing.write_hold_time;
      PH_WR_REC:    ph_time = WRITE_RECOVERY_TIME;
      PH_RD_LOW:    ph_time = timing.read_start_time;
      PH_RD_WAIT:   ph_time = timing.read_sample_time;
      PH_RD_TAIL:   ph_time = timing.read_tail_time;
      default:      ph_time = DEFAULT_PHASE_TIME;
    endcase
    ph_last_raw = (ph_time == '0) ? '0 : ph_time - REG_WIDTH'(1);
    ph_last_ext = LIM_WIDTH'(ph_last_raw);
    if (ph_last_ext > COUNT_MAX) begin
      ph_last_ext = COUNT_MAX;
    end
    ph_last = COUNT_WIDTH'(ph_last_ext);
  end

  assign phase_end = !(cur_tick < ph_last);

  // Next state: advance the counter or move to the next phase
  always_comb begin
    phase_next         = cur_phase;
    tick_count_next    = '0;
    bit_index_next     = cur_bit;
    shift_byte_next    = cur_shift;
    presence_flag_next = presence_flag;
    held_read_next     = held_read;
    if (cur_phase != PH_IDLE) begin
      if (!phase_end) begin
        tick_count_next = cur_tick + COUNT_WIDTH'(1);
      end else begin
        unique case (cur_phase)
          PH_PRE:       phase_next = PH_RST_LOW;
          PH_RST_LOW:   phase_next = PH_PRES_WAIT;
          PH_PRES_WAIT: begin
            presence_flag_next = line_level;
            phase_next         = PH_RST_REC;
          end
          PH_RST_REC:   phase_next = PH_IDLE;
          PH_WR_LOW:    phase_next = PH_WR_DATA;
          PH_WR_DATA:   phase_next = PH_WR_REC;
          PH_WR_REC: begin
            shift_byte_next = {1'b0, cur_shift[BYTE_WIDTH-1:1]};
            if (cur_bit == LAST_BIT) begin
              phase_next     = PH_IDLE;
              bit_index_next = '0;
            end else begin
              phase_next     = PH_WR_LOW;
              bit_index_next = cur_bit + BIT_IDX_WIDTH'(1);
            end
          end
          PH_RD_LOW:    phase_next = PH_RD_WAIT;
          PH_RD_WAIT: begin
            shift_byte_next = {line_level, cur_shift[BYTE_WIDTH-1:1]};
            phase_next      = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            if (cur_bit == LAST_BIT) begin
              held_read_next = cur_shift;
              phase_next     = PH_IDLE;
              bit_index_next = '0;
            end else begin
              phase_next     = PH_RD_LOW;
              bit_index_next = cur_bit + BIT_IDX_WIDTH'(1);
            end
          end
          default:      phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // Outputs: line drive, busy, done and the held samples
  always_comb begin
    result.busy_res       = (cur_phase != PH_IDLE);
    result.presence_level = presence_flag_next;
    result.read_byte      = held_read_next;
    result.done_res       = 1'b0;
    unique case (cur_phase)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: result.line_release = 1'b0;
      PH_WR_DATA:                       result.line_release = cur_shift[0];
      default:                          result.line_release = 1'b1;
    endcase
    if (phase_end) begin
      unique case (cur_phase)
        PH_RST_REC:            result.done_res = 1'b1;
        PH_WR_REC, PH_RD_TAIL: result.done_res = (cur_bit == LAST_BIT);
        default:               result.done_res = 1'b0;
      endcase
    end
  end

  // Commit state once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b1;
      held_read     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      held_read     <= held_read_next;
    end
  end

endmodule

[src/one_wire_bus_master.sv]
// Top level of the 1-Wire bus master: channel handshakes, result register,
// timing register file and phase sequencer. Depends on owb_pkg, the owb
// interfaces, owb_regs and owb_core.
//
//   channel     dir  handshake     payload
//   item_in     in   valid/ready   mode, write_byte, line_level
//   result_out  out  valid/ready   line_release, busy_res, done_res,
//                                  presence_level, read_byte
//   cfg         in   valid/ready   index, data (always ready)
//
// One item per cycle unless a stalled consumer holds input back: each item is
// one microsecond tick, worked in a single pass of the phase counter compare
// and captured in the result register, shown in the cycle after its acceptance.
// Input ready is high while the result register is empty or being taken,
// so a stalled consumer holds input back without losing a result.
// Reset (rst, synchronous) leaves the bus idle and released, timing
// registers at their defaults and the result register empty.
module one_wire_bus_master import owb_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  owb_in_if.sink    item_in,
  owb_out_if.source result_out,
  owb_cfg_if.sink   cfg
);

  timing_t timing;
  result_t result;
  result_t out_data;
  logic    out_valid;
  logic    accept;

  assign cfg.ready     = 1'b1;
  assign item_in.ready = !out_valid || result_out.ready;
  assign accept        = item_in.valid && item_in.ready;

  owb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .timing   (timing)
  );

  owb_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .mode       (item_in.mode),
    .write_byte (item_in.write_byte),
    .line_level (item_in.line_level),
    .timing     (timing),
    .result     (result)
  );

  // Hold the result until taken; load a new one on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.line_release   = out_data.line_release;
  assign result_out.busy_res       = out_data.busy_res;
  assign result_out.done_res       = out_data.done_res;
  assign result_out.presence_level = out_data.presence_level;
  assign result_out.read_byte      = out_data.read_byte;

endmodule

[sim/one_wire_bus_master_tb.sv]
// Testbench for one_wire_bus_master: drives reset, write and read operations
// with random gaps, predicts every result tick and checks it in order.
// Depends on owb_pkg, the owb interfaces and the one_wire_bus_master RTL.
module one_wire_bus_master_tb import owb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W      = COUNT_WIDTH_DEF;
  localparam int NUM_REGS     = 1 << REG_IDX_WIDTH;
  localparam int MAX_SHOWN    = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 200;
  localparam int RANDOM_ITEMS = 380;
  localparam int SETTLE       = 8;

  typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_pick_t;

  // Bus master predictor and in-order result checker
  class bus_scoreboard;
    phase_t               ph;
    logic [COUNT_W-1:0]   tick_cnt;
    logic [BIT_IDX_WIDTH-1:0] bit_idx;
    logic [BYTE_WIDTH-1:0] shift_q;
    logic                 presence_q;
    logic                 drive_q;
    logic [BYTE_WIDTH-1:0] read_hold;
    logic [REG_WIDTH-1:0] timing [NUM_REGS];
    result_t              expected_q [$];
    int                   errors;
    int                   result_idx;

    function new();
      ph         = PH_IDLE;
      tick_cnt   = '0;
      bit_idx    = '0;
      shift_q    = '0;
      presence_q = 1'b1;
      drive_q    = 1'b1;
      read_hold  = '0;
      errors     = 0;
      result_idx = 0;
      timing[REG_RESET_LOW]     = RESET_LOW_RST;
      timing[REG_PRESENCE_WAIT] = PRESENCE_WAIT_RST;
      timing[REG_RESET_REC]     = RESET_REC_RST;
      timing[REG_WRITE_START]   = WRITE_START_RST;
      timing[REG_WRITE_HOLD]    = WRITE_HOLD_RST;
      timing[REG_READ_START]    = READ_START_RST;
      timing[REG_READ_SAMPLE]   = READ_SAMPLE_RST;
      timing[REG_READ_TAIL]     = READ_TAIL_RST;
    endfunction

    function void set_timing(cfg_reg_t idx, logic [REG_WIDTH-1:0] val);
      timing[idx] = val;
    endfunction

    function bit idle();
      return ph == PH_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Length in ticks of the given phase
    function int phase_len(phase_t p);
      case (p)
        PH_PRE:       return PRE_HIGH_TIME;
        PH_RST_LOW:   return timing[REG_RESET_LOW];
        PH_PRES_WAIT: return timing[REG_PRESENCE_WAIT];
        PH_RST_REC:   return timing[REG_RESET_REC];
        PH_WR_LOW:    return timing[REG_WRITE_START];
        PH_WR_DATA:   return timing[REG_WRITE_HOLD];
        PH_WR_REC:    return WRITE_RECOVERY_TIME;
        PH_RD_LOW:    return timing[REG_READ_START];
        PH_RD_WAIT:   return timing[REG_READ_SAMPLE];
        PH_RD_TAIL:   return timing[REG_READ_TAIL];
        default:      return DEFAULT_PHASE_TIME;
      endcase
    endfunction

    // Advance one microsecond tick and queue the result it produces
    function void note_item(mode_t m, logic [BYTE_WIDTH-1:0] wb, logic line);
      result_t r;
      int      last;
      r = '0;
      // start a new operation only from idle
      if (ph == PH_IDLE) begin
        tick_cnt = '0;
        bit_idx  = '0;
        case (m)
          MODE_RESET: ph = PH_PRE;
          MODE_WRITE: begin
            shift_q = wb;
            ph      = PH_WR_LOW;
          end
          MODE_READ: begin
            shift_q = '0;
            ph      = PH_RD_LOW;
          end
          default: ;
        endcase
      end
      if (ph == PH_IDLE) begin
        drive_q = 1'b1;
      end else begin
        r.busy_res = 1'b1;
        if (ph == PH_RST_LOW || ph == PH_WR_LOW || ph == PH_RD_LOW) drive_q = 1'b0;
        else if (ph == PH_WR_DATA) drive_q = shift_q[0];
        else drive_q = 1'b1;
        last = phase_len(ph);
        last = (last == 0) ? 0 : last - 1;
        if (last > (1 << COUNT_W) - 1) last = (1 << COUNT_W) - 1;
        if (int'(tick_cnt) < last) begin
          tick_cnt = tick_cnt + 1'b1;
        end else begin
          // end of phase: step to the next one
          tick_cnt = '0;
          case (ph)
            PH_PRE:     ph = PH_RST_LOW;
            PH_RST_LOW: ph = PH_PRES_WAIT;
            PH_PRES_WAIT: begin
              presence_q = line;
              ph         = PH_RST_REC;
            end
            PH_RST_REC: begin
              r.done_res = 1'b1;
              ph         = PH_IDLE;
            end
            PH_WR_LOW:  ph = PH_WR_DATA;
            PH_WR_DATA: ph = PH_WR_REC;
            PH_WR_REC: begin
              shift_q = shift_q >> 1;
              if (bit_idx == LAST_BIT) begin
                r.done_res = 1'b1;
                ph         = PH_IDLE;
                bit_idx    = '0;
              end else begin
                bit_idx = bit_idx + 1'b1;
                ph      = PH_WR_LOW;
              end
            end
            PH_RD_LOW: ph = PH_RD_WAIT;
            PH_RD_WAIT: begin
              shift_q = {line, shift_q[BYTE_WIDTH-1:1]};
              ph      = PH_RD_TAIL;
            end
            default: begin
              if (bit_idx == LAST_BIT) begin
                read_hold  = shift_q;
                r.done_res = 1'b1;
                ph         = PH_IDLE;
                bit_idx    = '0;
              end else begin
                bit_idx = bit_idx + 1'b1;
                ph      = PH_RD_LOW;
              end
            end
          endcase
        end
      end
      r.line_release   = drive_q;
      r.presence_level = presence_q;
      r.read_byte      = read_hold;
      expected_q.push_back(r);
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(result_t got);
      result_t exp;
      result_idx++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("result %0d arrived with no item pending: got %h", result_idx, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.line_release !== exp.line_release || got.busy_res !== exp.busy_res ||
          got.done_res !== exp.done_res || got.presence_level !== exp.presence_level ||
          got.read_byte !== exp.read_byte) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("result %0d mismatch: expected release=%b busy=%b done=%b pres=%b",
                   result_idx, exp.line_release, exp.busy_res, exp.done_res,
                   exp.presence_level, " byte=%02h, got release=%b busy=%b done=%b",
                   exp.read_byte, got.line_release, got.busy_res, got.done_res,
                   " pres=%b byte=%02h", got.presence_level, got.read_byte);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  owb_in_if  item_in ();
  owb_out_if result_out ();
  owb_cfg_if cfg ();

  one_wire_bus_master dut (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .result_out(result_out),
    .cfg       (cfg)
  );

  bus_scoreboard sb = new();
  result_t       seen_result;
  int            items_sent;
  int            results_seen;
  int            stall_cycles;
  int            tx_quiet;
  int            rx_quiet;

  assign seen_result = {result_out.line_release, result_out.busy_res, result_out.done_res,
                        result_out.presence_level, result_out.read_byte};

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check results before noting new items; a result always trails its item
  always @(posedge clk) begin
    if (!rst) begin
      if (result_out.valid && result_out.ready) begin
        sb.check_result(seen_result);
        results_seen <= results_seen + 1;
      end
      if (item_in.valid && item_in.ready)
        sb.note_item(mode_t'(item_in.mode), item_in.write_byte, item_in.line_level);
      if (cfg.valid && cfg.ready)
        sb.set_timing(cfg_reg_t'(cfg.index), cfg.data);
    end
  end

  // Count cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (result_out.valid && result_out.ready) ||
        (cfg.valid && cfg.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("one_wire_bus_master verification failed");
    $finish;
  end

  // Mostly short gaps, a few long ones, and occasional quiet stretches
  function automatic int pick_gap(inout int quiet);
    int roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 3) begin
      quiet = $urandom_range(300, 50);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic pick_line(line_pick_t lp);
    case (lp)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(1, 0));
    endcase
  endfunction

  // Receiver: random stalls plus one long hold-off to back up the input
  initial begin
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    result_out.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        result_out.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = pick_gap(rx_quiet);
      if (stall > 0) begin
        result_out.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_out.ready = 1'b1;
      @(negedge clk);
    end
  end

  // Offer one item and hold it until accepted; valid stays high on return
  task send_item(mode_t m, logic [BYTE_WIDTH-1:0] wb, logic line);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      item_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_in.valid      = 1'b1;
    item_in.mode       = m;
    item_in.write_byte = wb;
    item_in.line_level = line;
    do @(posedge clk); while (!item_in.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Start an operation, then tick with random noise until the bus is idle
  task run_op(mode_t m, logic [BYTE_WIDTH-1:0] wb, line_pick_t lp);
    send_item(m, wb, pick_line(lp));
    while (!sb.idle())
      send_item(mode_t'($urandom_range(3, 0)), BYTE_WIDTH'($urandom_range(255, 0)),
                pick_line(lp));
  endtask

  task random_op();
    int    roll;
    mode_t m;
    roll = $urandom_range(99, 0);
    if (roll < 30) m = MODE_RESET;
    else if (roll < 60) m = MODE_WRITE;
    else if (roll < 90) m = MODE_READ;
    else m = MODE_TICK;
    run_op(m, BYTE_WIDTH'($urandom_range(255, 0)), LINE_RANDOM);
  endtask

  // Drop valid and wait for every pending result
  task drain();
    item_in.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task write_reg(cfg_reg_t idx, logic [REG_WIDTH-1:0] val);
    int gap;
    gap = $urandom_range(2, 0);
    if (gap > 0) begin
      cfg.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  // Write every timing register with a value in [lo, hi]
  task program_regs(int lo, int hi);
    cfg_reg_t r;
    r = r.first();
    do begin
      write_reg(r, REG_WIDTH'($urandom_range(hi, lo)));
      r = r.next();
    end while (r != r.first());
    cfg.valid = 1'b0;
  endtask

  initial begin
    int random_start;
    rst                = 1'b1;
    item_in.valid      = 1'b0;
    item_in.mode       = MODE_TICK;
    item_in.write_byte = '0;
    item_in.line_level = 1'b1;
    cfg.valid          = 1'b0;
    cfg.index          = REG_RESET_LOW;
    cfg.data           = '0;
    items_sent         = 0;
    results_seen       = 0;
    tx_quiet           = 0;
    rx_quiet           = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default timings: a bare tick and one full write slot sequence
    run_op(MODE_TICK, 8'hFF, LINE_RANDOM);
    run_op(MODE_WRITE, 8'hA5, LINE_RANDOM);
    drain();

    // Zero timings: every programmable phase lasts one tick
    program_regs(0, 0);
    run_op(MODE_RESET, 8'h00, LINE_LOW);
    run_op(MODE_RESET, 8'hFF, LINE_HIGH);
    run_op(MODE_WRITE, 8'hA5, LINE_RANDOM);
    run_op(MODE_READ, 8'hFF, LINE_LOW);
    run_op(MODE_READ, 8'h00, LINE_HIGH);
    run_op(MODE_WRITE, 8'h5A, LINE_RANDOM);
    run_op(MODE_TICK, 8'h3C, LINE_RANDOM);
    drain();

    // Random operations over a series of short timing settings
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      program_regs(0, $urandom_range(6, 1));
      repeat ($urandom_range(10, 4)) random_op();
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("one_wire_bus_master verification clean");
    else
      $display("one_wire_bus_master verification failed");
    $finish;
  end

endmodule

[filelist.f]
src/owb_pkg.sv
src/owb_in_if.sv
src/owb_out_if.sv
src/owb_cfg_if.sv
src/owb_regs.sv
src/owb_core.sv
src/one_wire_bus_master.sv
sim/one_wire_bus_master_tb.sv
